// ===== rtl/scht_pkg.sv =====
// Shared types, constants and codes of the sorted-chain hash table.
package scht_pkg;

    localparam int unsigned KEY_W     = 31;
    localparam int unsigned BKT_W     = 4;
    localparam int unsigned MAX_BKTS  = 16;
    localparam int unsigned CHAIN_D   = 8;
    localparam int unsigned IDX_W     = 3;
    localparam int unsigned CNT_W     = 4;
    localparam int unsigned ADDR_W    = BKT_W + IDX_W;
    localparam int unsigned MEM_D     = MAX_BKTS * CHAIN_D;
    localparam int unsigned NB_W      = 5;
    localparam int unsigned HCNT_W    = 5;
    localparam int unsigned PADDR_W   = 3;

    // operation codes
    typedef enum logic [2:0] {
        FN_INSERT = 3'd0,
        FN_SEARCH = 3'd1,
        FN_DELETE = 3'd2,
        FN_UPDATE = 3'd3,
        FN_DUMP   = 3'd4
    } t_func;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_MISS  = 3'd1,
        ST_FULL  = 3'd2,
        ST_EMPTY = 3'd3,
        ST_BAD   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        CB_B   = 2'd0,
        CB_NB  = 2'd1,
        CB_SEL = 2'd2
    } t_cb_sel;

    typedef enum logic [1:0] {
        AD_CUR  = 2'd0,
        AD_PREV = 2'd1,
        AD_NEXT = 2'd2
    } t_addr_sel;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_HASH_K,
        S_HASH_N,
        S_DUMP_CHK,
        S_DUMP_CNT,
        S_DUMP_RD,
        S_DUMP_EMIT,
        S_FIND_RD,
        S_FIND_CMP,
        S_INS_START,
        S_INS_RD,
        S_INS_CMP,
        S_INS_WR,
        S_REM_RD,
        S_REM_WR,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [2:0]       func;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] new_key;
        logic [BKT_W-1:0] bucket_sel;
    } t_in_word;

    typedef struct packed {
        logic [2:0]       status;
        logic [BKT_W-1:0] bucket;
        logic [3:0]       position;
        logic [KEY_W-1:0] key_out;
        logic             last;
    } t_out_word;

    // controller to datapath
    typedef struct packed {
        logic      load;
        logic      hash_start;
        logic      hash_nkey;
        logic      set_b;
        logic      set_nb;
        logic      cb_load;
        t_cb_sel   cb_sel;
        logic      tgt_nkey;
        logic      i_clr;
        logic      i_load_cnt;
        logic      i_inc;
        logic      i_dec;
        logic      rd_en;
        logic      wr_en;
        logic      wr_tgt;
        t_addr_sel addr_sel;
        logic      cnt_inc;
        logic      cnt_dec;
        logic      pos_found;
        logic      pos_ins;
        logic      full_save;
        logic      st_load;
        t_status   st_val;
        logic      emit;
        logic      emit_dump;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_func func;
        logic  hash_done;
        logic  i_eq_cnt;
        logic  i_zero;
        logic  i1_ge_cnt;
        logic  cnt_zero;
        logic  cnt_full;
        logic  rd_eq;
        logic  rd_gt;
        logic  b_eq_nb;
        logic  full_nb;
        logic  sel_bad;
        logic  out_free;
        logic  dump_last;
    } t_stat;

endpackage

// ===== rtl/scht_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module scht_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/scht_datapath.sv =====
// Datapath: key store, chain counts, modulo unit, config register, result register.
module scht_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  scht_pkg::t_cmd                 i_cmd,
    output scht_pkg::t_stat                o_stat,
    input  scht_pkg::t_in_word             i_data,
    output scht_pkg::t_out_word            o_data,
    output logic                           o_valid,
    input  logic                           i_stall,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [scht_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata
);

    // input word held for the whole operation
    logic [2:0]                   r_func;
    logic [scht_pkg::KEY_W-1:0]   r_key;
    logic [scht_pkg::KEY_W-1:0]   r_nkey;
    logic [scht_pkg::BKT_W-1:0]   r_sel;

    logic [scht_pkg::NB_W-1:0]    r_num;
    logic [scht_pkg::NB_W-1:0]    eff;

    logic [scht_pkg::KEY_W-1:0]   r_div;
    logic [scht_pkg::BKT_W-1:0]   r_rem;
    logic [scht_pkg::HCNT_W-1:0]  r_hcnt;
    logic [scht_pkg::NB_W-1:0]    trial;

    logic [scht_pkg::BKT_W-1:0]   r_b;
    logic [scht_pkg::BKT_W-1:0]   r_nb;
    logic [scht_pkg::BKT_W-1:0]   r_cb;
    logic [scht_pkg::KEY_W-1:0]   r_tgt;
    logic [scht_pkg::CNT_W-1:0]   r_i;
    logic [scht_pkg::CNT_W-1:0]   r_pos;
    logic                         r_full_nb;
    scht_pkg::t_status            r_st;

    logic [scht_pkg::CNT_W-1:0]   r_cnt [scht_pkg::MAX_BKTS];
    logic [scht_pkg::CNT_W-1:0]   cur_cnt;
    logic [scht_pkg::CNT_W-1:0]   i_p1;
    logic [scht_pkg::CNT_W-1:0]   i_m1;
    logic [scht_pkg::IDX_W-1:0]   idx;
    logic [scht_pkg::ADDR_W-1:0]  addr;
    logic [scht_pkg::KEY_W-1:0]   rdata;
    logic [scht_pkg::KEY_W-1:0]   wdata;

    scht_pkg::t_out_word          r_out;
    logic                         r_ovalid;
    logic                         out_free;

    // effective bucket count: zero reads as one, anything above the maximum is cut
    always_comb begin
        if (r_num == '0) begin
            eff = scht_pkg::NB_W'(1);
        end else if (r_num > scht_pkg::NB_W'(scht_pkg::MAX_BKTS)) begin
            eff = scht_pkg::NB_W'(scht_pkg::MAX_BKTS);
        end else begin
            eff = r_num;
        end
    end

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num <= scht_pkg::NB_W'(scht_pkg::MAX_BKTS);
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_num <= pwdata[scht_pkg::NB_W-1:0];
        end
    end
    assign prdata = paddr[2] ? 32'd0 : {{(32-scht_pkg::NB_W){1'b0}}, r_num};

    // load the input word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_data.func;
            r_key  <= i_data.key;
            r_nkey <= i_data.new_key;
            r_sel  <= i_data.bucket_sel;
        end
    end

    // restoring modulo, one dividend bit a cycle
    assign trial = {r_rem, r_div[scht_pkg::KEY_W-1]};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hcnt <= '0;
        end else if (i_cmd.hash_start) begin
            r_hcnt <= scht_pkg::HCNT_W'(scht_pkg::KEY_W);
        end else if (r_hcnt != '0) begin
            r_hcnt <= r_hcnt - 1'b1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.hash_start) begin
            r_div <= i_cmd.hash_nkey ? r_nkey : r_key;
            r_rem <= '0;
        end else if (r_hcnt != '0) begin
            r_div <= {r_div[scht_pkg::KEY_W-2:0], 1'b0};
            if (trial >= eff) begin
                r_rem <= scht_pkg::BKT_W'(trial - eff);
            end else begin
                r_rem <= scht_pkg::BKT_W'(trial);
            end
        end
    end

    // bucket, target and walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_b) begin
            r_b <= r_rem;
        end
        if (i_cmd.set_nb) begin
            r_nb <= r_rem;
        end
        if (i_cmd.cb_load) begin
            // a bucket latched in the same cycle comes straight from the remainder
            unique case (i_cmd.cb_sel)
                scht_pkg::CB_B:   r_cb <= i_cmd.set_b ? r_rem : r_b;
                scht_pkg::CB_NB:  r_cb <= i_cmd.set_nb ? r_rem : r_nb;
                scht_pkg::CB_SEL: r_cb <= r_sel;
                default:          r_cb <= r_b;
            endcase
            r_tgt <= i_cmd.tgt_nkey ? r_nkey : r_key;
        end
        if (i_cmd.i_clr) begin
            r_i <= '0;
        end else if (i_cmd.i_load_cnt) begin
            r_i <= cur_cnt;
        end else if (i_cmd.i_inc) begin
            r_i <= i_p1;
        end else if (i_cmd.i_dec) begin
            r_i <= i_m1;
        end
        if (i_cmd.pos_found) begin
            r_pos <= i_p1;
        end else if (i_cmd.pos_ins) begin
            r_pos <= i_p1;
        end
        if (i_cmd.full_save) begin
            r_full_nb <= (cur_cnt >= scht_pkg::CNT_W'(scht_pkg::CHAIN_D));
        end
        if (i_cmd.st_load) begin
            r_st <= i_cmd.st_val;
        end
    end

    // chain counts, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < scht_pkg::MAX_BKTS; k++) begin
                r_cnt[k] <= '0;
            end
        end else if (i_cmd.cnt_inc) begin
            r_cnt[r_cb] <= cur_cnt + 1'b1;
        end else if (i_cmd.cnt_dec) begin
            r_cnt[r_cb] <= cur_cnt - 1'b1;
        end
    end
    assign cur_cnt = r_cnt[r_cb];

    assign i_p1 = r_i + 1'b1;
    assign i_m1 = r_i - 1'b1;

    always_comb begin
        unique case (i_cmd.addr_sel)
            scht_pkg::AD_CUR:  idx = r_i[scht_pkg::IDX_W-1:0];
            scht_pkg::AD_PREV: idx = i_m1[scht_pkg::IDX_W-1:0];
            scht_pkg::AD_NEXT: idx = i_p1[scht_pkg::IDX_W-1:0];
            default:           idx = r_i[scht_pkg::IDX_W-1:0];
        endcase
    end
    assign addr  = {r_cb, idx};
    assign wdata = i_cmd.wr_tgt ? r_tgt : rdata;

    scht_ram #(
        .WIDTH (scht_pkg::KEY_W),
        .DEPTH (scht_pkg::MEM_D)
    ) u_keys (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (addr),
        .i_wdata (wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (addr),
        .o_rdata (rdata)
    );

    // result register
    assign out_free = !r_ovalid || !i_stall;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit || i_cmd.emit_dump) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_dump) begin
            r_out.status   <= scht_pkg::ST_OK;
            r_out.bucket   <= r_sel;
            r_out.position <= i_p1;
            r_out.key_out  <= rdata;
            r_out.last     <= (i_p1 == cur_cnt);
        end else if (i_cmd.emit) begin
            r_out.status   <= r_st;
            r_out.bucket   <= (r_func == scht_pkg::FN_DUMP) ? r_sel : r_b;
            r_out.position <= (r_st == scht_pkg::ST_OK) ? r_pos : '0;
            r_out.key_out  <= '0;
            r_out.last     <= 1'b1;
        end
    end
    assign o_data  = r_out;
    assign o_valid = r_ovalid;

    // status to the controller
    assign o_stat.func      = scht_pkg::t_func'(r_func);
    assign o_stat.hash_done = (r_hcnt == '0);
    assign o_stat.i_eq_cnt  = (r_i == cur_cnt);
    assign o_stat.i_zero    = (r_i == '0);
    assign o_stat.i1_ge_cnt = (i_p1 >= cur_cnt);
    assign o_stat.cnt_zero  = (cur_cnt == '0);
    assign o_stat.cnt_full  = (cur_cnt >= scht_pkg::CNT_W'(scht_pkg::CHAIN_D));
    assign o_stat.rd_eq     = (rdata == r_tgt);
    assign o_stat.rd_gt     = (rdata > r_tgt);
    assign o_stat.b_eq_nb   = (r_b == r_nb);
    assign o_stat.full_nb   = r_full_nb;
    assign o_stat.sel_bad   = ({1'b0, r_sel} >= eff);
    assign o_stat.out_free  = out_free;
    assign o_stat.dump_last = (i_p1 == cur_cnt);

endmodule

// ===== rtl/scht_ctrl.sv =====
// Controller: sequences hashing, chain walks, shifts and result words.
module scht_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    output scht_pkg::t_cmd  o_cmd,
    input  scht_pkg::t_stat i_stat
);

    scht_pkg::t_state r_state;
    scht_pkg::t_state n_state;
    logic             r_upd2;
    logic             n_upd2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scht_pkg::S_IDLE;
            r_upd2  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_upd2  <= n_upd2;
        end
    end

    // next state and commands
    always_comb begin
        logic miss;
        logic found;
        n_state = r_state;
        n_upd2  = r_upd2;
        o_cmd   = '0;
        o_stall = 1'b1;
        miss    = 1'b0;
        found   = 1'b0;

        unique case (r_state)
            scht_pkg::S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = scht_pkg::S_DECODE;
                end
            end
            scht_pkg::S_DECODE: begin
                priority if (i_stat.func == scht_pkg::FN_DUMP) begin
                    n_state = scht_pkg::S_DUMP_CHK;
                end else if (i_stat.func == scht_pkg::FN_INSERT ||
                             i_stat.func == scht_pkg::FN_SEARCH ||
                             i_stat.func == scht_pkg::FN_DELETE ||
                             i_stat.func == scht_pkg::FN_UPDATE) begin
                    o_cmd.hash_start = 1'b1;
                    n_state          = scht_pkg::S_HASH_K;
                end else begin
                    n_state = scht_pkg::S_IDLE;
                end
            end
            scht_pkg::S_HASH_K: begin
                if (i_stat.hash_done) begin
                    o_cmd.set_b = 1'b1;
                    n_upd2      = 1'b0;
                    if (i_stat.func == scht_pkg::FN_UPDATE) begin
                        o_cmd.hash_start = 1'b1;
                        o_cmd.hash_nkey  = 1'b1;
                        n_state          = scht_pkg::S_HASH_N;
                    end else begin
                        o_cmd.cb_load = 1'b1;
                        o_cmd.cb_sel  = scht_pkg::CB_B;
                        o_cmd.i_clr   = 1'b1;
                        n_state       = scht_pkg::S_FIND_RD;
                    end
                end
            end
            scht_pkg::S_HASH_N: begin
                if (i_stat.hash_done) begin
                    // first look for the new key in its own bucket
                    o_cmd.set_nb = 1'b1;
                    n_state      = scht_pkg::S_FIND_RD;
                end
            end
            scht_pkg::S_DUMP_CHK: begin
                if (i_stat.sel_bad) begin
                    o_cmd.st_load = 1'b1;
                    o_cmd.st_val  = scht_pkg::ST_BAD;
                    n_state       = scht_pkg::S_EMIT;
                end else begin
                    o_cmd.cb_load = 1'b1;
                    o_cmd.cb_sel  = scht_pkg::CB_SEL;
                    n_state       = scht_pkg::S_DUMP_CNT;
                end
            end
            scht_pkg::S_DUMP_CNT: begin
                if (i_stat.cnt_zero) begin
                    o_cmd.st_load = 1'b1;
                    o_cmd.st_val  = scht_pkg::ST_EMPTY;
                    n_state       = scht_pkg::S_EMIT;
                end else begin
                    o_cmd.i_clr = 1'b1;
                    n_state     = scht_pkg::S_DUMP_RD;
                end
            end
            scht_pkg::S_DUMP_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = scht_pkg::S_DUMP_EMIT;
            end
            scht_pkg::S_DUMP_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_dump = 1'b1;
                    o_cmd.i_inc     = 1'b1;
                    n_state = i_stat.dump_last ? scht_pkg::S_IDLE : scht_pkg::S_DUMP_RD;
                end
            end
            scht_pkg::S_FIND_RD: begin
                if (i_stat.i_eq_cnt) begin
                    miss = 1'b1;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = scht_pkg::S_FIND_CMP;
                end
            end
            scht_pkg::S_FIND_CMP: begin
                priority if (i_stat.rd_eq) begin
                    found = 1'b1;
                end else if (i_stat.rd_gt) begin
                    miss = 1'b1;
                end else begin
                    o_cmd.i_inc = 1'b1;
                    n_state     = scht_pkg::S_FIND_RD;
                end
            end
            scht_pkg::S_INS_START: begin
                o_cmd.i_load_cnt = 1'b1;
                n_state          = scht_pkg::S_INS_RD;
            end
            scht_pkg::S_INS_RD: begin
                if (i_stat.i_zero) begin
                    n_state = scht_pkg::S_INS_WR;
                end else begin
                    o_cmd.rd_en    = 1'b1;
                    o_cmd.addr_sel = scht_pkg::AD_PREV;
                    n_state        = scht_pkg::S_INS_CMP;
                end
            end
            scht_pkg::S_INS_CMP: begin
                if (i_stat.rd_gt) begin
                    o_cmd.wr_en = 1'b1;
                    o_cmd.i_dec = 1'b1;
                    n_state     = scht_pkg::S_INS_RD;
                end else begin
                    n_state = scht_pkg::S_INS_WR;
                end
            end
            scht_pkg::S_INS_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_tgt  = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                o_cmd.pos_ins = (i_stat.func == scht_pkg::FN_INSERT);
                o_cmd.st_load = 1'b1;
                o_cmd.st_val  = scht_pkg::ST_OK;
                n_state       = scht_pkg::S_EMIT;
            end
            scht_pkg::S_REM_RD: begin
                if (i_stat.i1_ge_cnt) begin
                    o_cmd.cnt_dec = 1'b1;
                    if (i_stat.func == scht_pkg::FN_UPDATE) begin
                        o_cmd.cb_load  = 1'b1;
                        o_cmd.cb_sel   = scht_pkg::CB_NB;
                        o_cmd.tgt_nkey = 1'b1;
                        n_state        = scht_pkg::S_INS_START;
                    end else begin
                        o_cmd.st_load = 1'b1;
                        o_cmd.st_val  = scht_pkg::ST_OK;
                        n_state       = scht_pkg::S_EMIT;
                    end
                end else begin
                    o_cmd.rd_en    = 1'b1;
                    o_cmd.addr_sel = scht_pkg::AD_NEXT;
                    n_state        = scht_pkg::S_REM_WR;
                end
            end
            scht_pkg::S_REM_WR: begin
                o_cmd.wr_en = 1'b1;
                o_cmd.i_inc = 1'b1;
                n_state     = scht_pkg::S_REM_RD;
            end
            scht_pkg::S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = scht_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = scht_pkg::S_IDLE;
            end
        endcase

        // the new-key lookup of an update starts in its own bucket
        if (r_state == scht_pkg::S_HASH_N && i_stat.hash_done) begin
            o_cmd.cb_load  = 1'b1;
            o_cmd.cb_sel   = scht_pkg::CB_NB;
            o_cmd.tgt_nkey = 1'b1;
            o_cmd.i_clr    = 1'b1;
        end

        // key not in the chain
        if (miss) begin
            unique case (i_stat.func)
                scht_pkg::FN_INSERT: begin
                    if (i_stat.cnt_full) begin
                        o_cmd.st_load = 1'b1;
                        o_cmd.st_val  = scht_pkg::ST_FULL;
                        n_state       = scht_pkg::S_EMIT;
                    end else begin
                        n_state = scht_pkg::S_INS_START;
                    end
                end
                scht_pkg::FN_UPDATE: begin
                    if (!r_upd2) begin
                        // new key absent: note room in its bucket, then find the old key
                        o_cmd.full_save = 1'b1;
                        o_cmd.cb_load   = 1'b1;
                        o_cmd.cb_sel    = scht_pkg::CB_B;
                        o_cmd.i_clr     = 1'b1;
                        n_upd2          = 1'b1;
                        n_state         = scht_pkg::S_FIND_RD;
                    end else begin
                        o_cmd.st_load = 1'b1;
                        o_cmd.st_val  = scht_pkg::ST_MISS;
                        n_state       = scht_pkg::S_EMIT;
                    end
                end
                default: begin
                    o_cmd.st_load = 1'b1;
                    o_cmd.st_val  = scht_pkg::ST_MISS;
                    n_state       = scht_pkg::S_EMIT;
                end
            endcase
        end

        // key found at the current index
        if (found) begin
            unique case (i_stat.func)
                scht_pkg::FN_SEARCH: begin
                    o_cmd.pos_found = 1'b1;
                    o_cmd.st_load   = 1'b1;
                    o_cmd.st_val    = scht_pkg::ST_OK;
                    n_state         = scht_pkg::S_EMIT;
                end
                scht_pkg::FN_DELETE: begin
                    o_cmd.pos_found = 1'b1;
                    n_state         = scht_pkg::S_REM_RD;
                end
                scht_pkg::FN_UPDATE: begin
                    if (!r_upd2) begin
                        o_cmd.st_load = 1'b1;
                        o_cmd.st_val  = scht_pkg::ST_MISS;
                        n_state       = scht_pkg::S_EMIT;
                    end else if (!i_stat.b_eq_nb && i_stat.full_nb) begin
                        o_cmd.st_load = 1'b1;
                        o_cmd.st_val  = scht_pkg::ST_FULL;
                        n_state       = scht_pkg::S_EMIT;
                    end else begin
                        o_cmd.pos_found = 1'b1;
                        n_state         = scht_pkg::S_REM_RD;
                    end
                end
                default: begin
                    // duplicate insert
                    o_cmd.st_load = 1'b1;
                    o_cmd.st_val  = scht_pkg::ST_MISS;
                    n_state       = scht_pkg::S_EMIT;
                end
            endcase
        end
    end

endmodule

// ===== rtl/sorted_chain_hash_table_top.sv =====
// Top level of the sorted-chain hash table: controller, datapath and wiring.
//
//   channel | valid   | stall   | payload
//   --------+---------+---------+-------------------------
//   input   | i_valid | o_stall | i_data  (t_in_word)
//   result  | o_valid | i_stall | o_data  (t_out_word)
//   config  | APB write/read of num_buckets at address 0
//
// One word at a time. Each key hash is a restoring modulo over the 31 key bits,
// run twice for an update; a chain walk reads and then compares each entry
// (registered RAM read), and a shift reads and then writes each moved key.
// Reset clears every chain count at once; no clearing pass is needed.
// A stalled result holds in the output register; the dump walk and the final result wait on it.
module sorted_chain_hash_table_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  scht_pkg::t_in_word           i_data,
    output logic                         o_valid,
    input  logic                         i_stall,
    output scht_pkg::t_out_word          o_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [scht_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    scht_pkg::t_cmd  cmd;
    scht_pkg::t_stat stat;

    assign pready = 1'b1;

    scht_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_cmd   (cmd),
        .i_stat  (stat)
    );

    scht_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .i_data  (i_data),
        .o_data  (o_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata)
    );

endmodule
